// ===== src/salsa_pkg.sv =====
// Shared types, constants and helpers for the Salsa20/8 core pipeline.
// Depends on nothing; used by salsa_stage, salsa_final and salsa20_8_core.
package salsa_pkg;

   localparam int ROUND_COUNT = 8;
   localparam int STEP_COUNT  = 4 * ROUND_COUNT;

   typedef logic [15:0][31:0] word_block_type;

   typedef struct packed {
      word_block_type work;
      word_block_type orig;
   } stage_data_type;

   // Which add-rotate-xor step a stage runs: round kind and step within the quarter.
   typedef struct packed {
      logic       row;
      logic [1:0] pos;
   } step_sel_type;

   localparam logic [3:0] COL_IDX [4][4] = '{
      '{4'd0,  4'd4,  4'd8,  4'd12},
      '{4'd5,  4'd9,  4'd13, 4'd1 },
      '{4'd10, 4'd14, 4'd2,  4'd6 },
      '{4'd15, 4'd3,  4'd7,  4'd11}
   };

   localparam logic [3:0] ROW_IDX [4][4] = '{
      '{4'd0,  4'd1,  4'd2,  4'd3 },
      '{4'd5,  4'd6,  4'd7,  4'd4 },
      '{4'd10, 4'd11, 4'd8,  4'd9 },
      '{4'd15, 4'd12, 4'd13, 4'd14}
   };

   localparam logic [4:0] ROT_AMT [4] = '{5'd7, 5'd9, 5'd13, 5'd18};

   function automatic logic [3:0] quarter_idx(logic row, logic [1:0] q, logic [1:0] pos);
      return row ? ROW_IDX[q][pos] : COL_IDX[q][pos];
   endfunction

   function automatic logic [31:0] rotl32(logic [31:0] v, logic [4:0] s);
      logic [63:0] t;
      t = {v, v} << s;
      return t[63:32];
   endfunction

   // Stage s runs step s mod 4 of round s / 4; even rounds are column rounds.
   function automatic step_sel_type stage_sel(int s);
      step_sel_type sel;
      sel.row = s[2];
      sel.pos = s[1:0];
      return sel;
   endfunction

endpackage

// ===== src/salsa_stage.sv =====
// One pipeline stage: one add-rotate-xor step applied to all four quarters.
// Depends on salsa_pkg.
module salsa_stage
   import salsa_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           advance,
   input  step_sel_type   sel,
   input  logic           in_valid,
   input  stage_data_type in_data,
   output logic           out_valid,
   output stage_data_type out_data
);

   logic           valid_ff;
   logic           valid_in;
   stage_data_type data_ff;
   stage_data_type data_in;

   always_comb begin
      logic [3:0] dst;
      logic [3:0] src_a;
      logic [3:0] src_b;
      data_in = in_data;
      for (int q = 0; q < 4; q++) begin
         dst   = quarter_idx(sel.row, 2'(q), sel.pos + 2'd1);
         src_a = quarter_idx(sel.row, 2'(q), sel.pos);
         src_b = quarter_idx(sel.row, 2'(q), sel.pos + 2'd3);
         data_in.work[dst] = in_data.work[dst]
            ^ rotl32(in_data.work[src_a] + in_data.work[src_b], ROT_AMT[sel.pos]);
      end
   end

   assign valid_in = advance ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== src/salsa_final.sv =====
// Last stage: add the original block to the working words, word by word.
// Depends on salsa_pkg.
module salsa_final
   import salsa_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           advance,
   input  logic           in_valid,
   input  stage_data_type in_data,
   output logic           out_valid,
   output word_block_type out_words
);

   logic           valid_ff;
   logic           valid_in;
   word_block_type sum_ff;
   word_block_type sum_in;

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         sum_in[i] = in_data.work[i] + in_data.orig[i];
      end
   end

   assign valid_in = advance ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sum_ff <= sum_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_words = sum_ff;

endmodule

// ===== src/salsa20_8_core.sv =====
// Salsa20/8 core, top level: 32 step stages and a feed-forward add stage.
// Depends on salsa_pkg, salsa_stage and salsa_final.
//
// Usage:
//   Input channel (req_valid / req_ready): one 512-bit block as eight 64-bit
//   fields, field i holding word 2i in bits 31..0 and word 2i+1 in 63..32.
//   Output channel (rsp_valid / rsp_ready): the sixteen result words, packed
//   the same way. One response per request, in request order.
// Pipeline and throughput:
//   Each round is four register stages, one add-rotate-xor step per stage,
//   applied to all four quarters at once; 8 rounds give 32 stages, then one
//   stage adds the original block; its register drives the response. One
//   request per cycle is accepted while rsp_ready does not hold the
//   pipeline; the 32-bit add and rotate in each stage sets the clock
//   period.
// Reset:
//   Synchronous, active high. Clears all valid bits; data registers hold
//   whatever they had. The block keeps no state between requests.
// Stall:
//   When a response is held with rsp_ready low, the whole pipeline holds
//   and req_ready drops in the same cycle; nothing is lost or repeated.
module salsa20_8_core
   import salsa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_in_words_0_1,
   input  logic [63:0] req_in_words_2_3,
   input  logic [63:0] req_in_words_4_5,
   input  logic [63:0] req_in_words_6_7,
   input  logic [63:0] req_in_words_8_9,
   input  logic [63:0] req_in_words_10_11,
   input  logic [63:0] req_in_words_12_13,
   input  logic [63:0] req_in_words_14_15,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_out_words_0_1,
   output logic [63:0] rsp_out_words_2_3,
   output logic [63:0] rsp_out_words_4_5,
   output logic [63:0] rsp_out_words_6_7,
   output logic [63:0] rsp_out_words_8_9,
   output logic [63:0] rsp_out_words_10_11,
   output logic [63:0] rsp_out_words_12_13,
   output logic [63:0] rsp_out_words_14_15
);

   // Advance every stage together unless the response register is held.
   logic           advance;
   word_block_type in_block;
   word_block_type out_block;
   stage_data_type pipe_data  [STEP_COUNT + 1];
   logic           pipe_valid [STEP_COUNT + 1];

   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   // Unpack: even word in the low half, odd word in the high half.
   assign in_block[0]  = req_in_words_0_1[31:0];
   assign in_block[1]  = req_in_words_0_1[63:32];
   assign in_block[2]  = req_in_words_2_3[31:0];
   assign in_block[3]  = req_in_words_2_3[63:32];
   assign in_block[4]  = req_in_words_4_5[31:0];
   assign in_block[5]  = req_in_words_4_5[63:32];
   assign in_block[6]  = req_in_words_6_7[31:0];
   assign in_block[7]  = req_in_words_6_7[63:32];
   assign in_block[8]  = req_in_words_8_9[31:0];
   assign in_block[9]  = req_in_words_8_9[63:32];
   assign in_block[10] = req_in_words_10_11[31:0];
   assign in_block[11] = req_in_words_10_11[63:32];
   assign in_block[12] = req_in_words_12_13[31:0];
   assign in_block[13] = req_in_words_12_13[63:32];
   assign in_block[14] = req_in_words_14_15[31:0];
   assign in_block[15] = req_in_words_14_15[63:32];

   // The working copy and the original both start as the request block.
   assign pipe_valid[0]     = req_valid;
   assign pipe_data[0].work = in_block;
   assign pipe_data[0].orig = in_block;

   for (genvar s = 0; s < STEP_COUNT; s++) begin : g_step
      salsa_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .sel       (stage_sel(s)),
         .in_valid  (pipe_valid[s]),
         .in_data   (pipe_data[s]),
         .out_valid (pipe_valid[s + 1]),
         .out_data  (pipe_data[s + 1])
      );
   end

   // Feed-forward add doubles as the output register.
   salsa_final u_final (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (pipe_valid[STEP_COUNT]),
      .in_data   (pipe_data[STEP_COUNT]),
      .out_valid (rsp_valid),
      .out_words (out_block)
   );

   assign rsp_out_words_0_1   = {out_block[1],  out_block[0]};
   assign rsp_out_words_2_3   = {out_block[3],  out_block[2]};
   assign rsp_out_words_4_5   = {out_block[5],  out_block[4]};
   assign rsp_out_words_6_7   = {out_block[7],  out_block[6]};
   assign rsp_out_words_8_9   = {out_block[9],  out_block[8]};
   assign rsp_out_words_10_11 = {out_block[11], out_block[10]};
   assign rsp_out_words_12_13 = {out_block[13], out_block[12]};
   assign rsp_out_words_14_15 = {out_block[15], out_block[14]};

   // Hold off requests only while a response is waiting on the receiver.
   a_ready_only_on_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("req_ready low without a held response");

   // Reset drains the pipeline.
   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> (!rsp_valid && !pipe_valid[1]))
      else $error("valid bits not cleared by reset");

   // A moving pipeline captures the request valid into the first stage.
   a_first_stage_load: assert property (@(posedge clock) disable iff (reset)
      advance |=> (pipe_valid[1] == $past(req_valid)))
      else $error("first stage valid does not follow the request");

   // A held pipeline keeps the last step's valid bit.
   a_last_stage_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> (pipe_valid[STEP_COUNT] == $past(pipe_valid[STEP_COUNT])))
      else $error("last step stage changed during a stall");

endmodule
